// ===== design/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg: shared definitions for the circular deque
// depth, field widths, operation and status codes, cell command type
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH         = 8;
    localparam int IDX_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int DATA_W        = 32;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 4;

    // operation codes, code 3 is ignored
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    // what every cell does this cycle
    typedef enum logic [1:0] {
        MODE_HOLD       = 2'd0,
        MODE_SHIFT_BACK = 2'd1,  // take the neighbor nearer the front
        MODE_SHIFT_FWD  = 2'd2,  // take the neighbor nearer the rear
        MODE_LOAD       = 2'd3   // selected cell takes the new value
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode       mode;
        logic [IDX_W-1:0] load_idx;
    } t_cell_cmd;

endpackage

// ===== design/cdq_if.sv =====
// ----------------------------------------------------------------------------
// cdq_if: request and response channels of the circular deque
// valid/ready handshake with the payload fields of each transaction
// ----------------------------------------------------------------------------
interface cdq_req_if;
    logic                               valid;
    logic                               ready;
    logic [cdq_pkg::OP_W-1:0]           operation;
    logic signed [cdq_pkg::DATA_W-1:0]  value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface cdq_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic [cdq_pkg::STATUS_W-1:0]            status;
    logic signed [cdq_pkg::DATA_W-1:0]       popped_value;
    logic [cdq_pkg::ENTRY_COUNT_W-1:0]       entry_count;

    modport source (output valid, output status, output popped_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input popped_value,
                    input entry_count, output ready);
endinterface

// ===== design/cdq_cell.sv =====
// ----------------------------------------------------------------------------
// cdq_cell: one storage cell of the deque chain
// holds one entry and loads from either neighbor or from the push value
// ----------------------------------------------------------------------------
module cdq_cell (
    input  logic                              i_clk,
    input  cdq_pkg::t_cell_cmd                i_cmd,
    input  logic [cdq_pkg::IDX_W-1:0]         i_idx,
    input  logic signed [cdq_pkg::DATA_W-1:0] i_value,
    input  logic signed [cdq_pkg::DATA_W-1:0] i_from_front,
    input  logic signed [cdq_pkg::DATA_W-1:0] i_from_rear,
    output logic signed [cdq_pkg::DATA_W-1:0] o_data
);

    logic signed [cdq_pkg::DATA_W-1:0] r_data;
    logic signed [cdq_pkg::DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_cmd.mode)
            cdq_pkg::MODE_HOLD:       n_data = r_data;
            cdq_pkg::MODE_SHIFT_BACK: n_data = i_from_front;
            cdq_pkg::MODE_SHIFT_FWD:  n_data = i_from_rear;
            cdq_pkg::MODE_LOAD: begin
                if (i_cmd.load_idx == i_idx) begin
                    n_data = i_value;
                end
            end
            default:                  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== design/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl: fill count and command decode for the deque chain
// tracks the entry count and tells the cells to shift, load or hold
// ----------------------------------------------------------------------------
module cdq_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic [cdq_pkg::OP_W-1:0]           i_operation,
    output cdq_pkg::t_cell_cmd                 o_cmd,
    output logic [cdq_pkg::STATUS_W-1:0]       o_status,
    output logic                               o_pop_ok,
    output logic [cdq_pkg::CNT_W-1:0]          o_count,
    output logic [cdq_pkg::CNT_W-1:0]          o_count_next
);

    logic [cdq_pkg::CNT_W-1:0] r_count;
    logic [cdq_pkg::CNT_W-1:0] n_count;
    logic                      full;
    logic                      empty;

    assign full  = (r_count == cdq_pkg::CNT_W'(cdq_pkg::DEPTH));
    assign empty = (r_count == '0);

    always_comb begin
        n_count          = r_count;
        o_cmd.mode       = cdq_pkg::MODE_HOLD;
        o_cmd.load_idx   = r_count[cdq_pkg::IDX_W-1:0];
        o_status         = cdq_pkg::ST_DONE;
        o_pop_ok         = 1'b0;
        if (i_operation == cdq_pkg::OP_PUSH_REAR || i_operation == cdq_pkg::OP_PUSH_FRONT) begin
            if (full) begin
                o_status = cdq_pkg::ST_OVERFLOW;
            end else begin
                n_count    = r_count + 1'b1;
                o_cmd.mode = (i_operation == cdq_pkg::OP_PUSH_REAR) ?
                             cdq_pkg::MODE_LOAD : cdq_pkg::MODE_SHIFT_BACK;
            end
        end else if (i_operation == cdq_pkg::OP_POP_FRONT) begin
            if (empty) begin
                o_status = cdq_pkg::ST_UNDERFLOW;
            end else begin
                n_count    = r_count - 1'b1;
                o_cmd.mode = cdq_pkg::MODE_SHIFT_FWD;
                o_pop_ok   = 1'b1;
            end
        end
        if (!i_accept) begin
            o_cmd.mode = cdq_pkg::MODE_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

    assign o_count      = r_count;
    assign o_count_next = n_count;

endmodule

// ===== design/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue of DEPTH 32-bit entries
// a chain of storage cells kept packed with the front entry in cell zero
// ----------------------------------------------------------------------------
// usage
//   i_req carries one operation per transaction: push at rear, push at
//   front or pop from front, plus the value to push (ignored on pop)
//   o_rsp returns exactly one transaction per request: status (done,
//   overflow, underflow), the popped value (zero unless a pop succeeded)
//   and the entry count after the operation, modulo 16
// timing
//   one request per cycle while the output register is free or draining; the response
//   is loaded into the output register in the cycle after the request is taken
//   every cell shifts or loads in the same cycle, so the delay to the
//   response does not grow with the depth
// reset
//   synchronous active-low reset empties the deque and drops any pending
//   response; cell contents are left as they were and never read
// back-pressure
//   while o_rsp is stalled the request side keeps ready low, except in the
//   cycle in which the waiting response is taken
// ----------------------------------------------------------------------------
module circular_deque (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cdq_req_if.sink    i_req,
    cdq_rsp_if.source  o_rsp
);

    // handshake state
    logic                                   r_valid;
    logic                                   accept;

    // controller results
    cdq_pkg::t_cell_cmd                     cmd;
    logic [cdq_pkg::STATUS_W-1:0]           status;
    logic                                   pop_ok;
    logic [cdq_pkg::CNT_W-1:0]              count;
    logic [cdq_pkg::CNT_W-1:0]              count_next;

    // output register payload
    logic [cdq_pkg::STATUS_W-1:0]           r_status;
    logic signed [cdq_pkg::DATA_W-1:0]      r_popped;
    logic [cdq_pkg::ENTRY_COUNT_W-1:0]      r_entry_count;

    // cell outputs, index zero is the front of the deque
    logic signed [cdq_pkg::DATA_W-1:0]      cell_data [cdq_pkg::DEPTH];

    // take a new request whenever the output register is free or draining
    assign i_req.ready = !r_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    cdq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_operation  (i_req.operation),
        .o_cmd        (cmd),
        .o_status     (status),
        .o_pop_ok     (pop_ok),
        .o_count      (count),
        .o_count_next (count_next)
    );

    // chain of cells: front cell takes the value on a front push,
    // the rear cell has no neighbor behind it and just refills itself
    for (genvar gi = 0; gi < cdq_pkg::DEPTH; gi++) begin : g_cell
        logic signed [cdq_pkg::DATA_W-1:0] from_front;
        logic signed [cdq_pkg::DATA_W-1:0] from_rear;

        if (gi == 0) begin : g_head
            assign from_front = i_req.value;
        end else begin : g_body
            assign from_front = cell_data[gi-1];
        end

        if (gi == cdq_pkg::DEPTH - 1) begin : g_tail
            assign from_rear = cell_data[gi];
        end else begin : g_inner
            assign from_rear = cell_data[gi+1];
        end

        cdq_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cmd),
            .i_idx        (cdq_pkg::IDX_W'(gi)),
            .i_value      (i_req.value),
            .i_from_front (from_front),
            .i_from_rear  (from_rear),
            .o_data       (cell_data[gi])
        );
    end

    // output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    // response payload, popped value is read from the front cell before it shifts
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status      <= status;
            r_popped      <= pop_ok ? cell_data[0] : '0;
            r_entry_count <= cdq_pkg::ENTRY_COUNT_W'(count_next);
        end
    end

    assign o_rsp.valid        = r_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.popped_value = r_popped;
    assign o_rsp.entry_count  = r_entry_count;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // fill count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= cdq_pkg::CNT_W'(cdq_pkg::DEPTH))
        else $error("fill count above depth");

    // every accepted request produces a response in the next cycle
    a_resp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_rsp.valid)
        else $error("response missing after accepted request");

    // underflow only from an empty deque and never returns data
    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == cdq_pkg::ST_UNDERFLOW)
        |-> (o_rsp.popped_value == '0 && o_rsp.entry_count == '0))
        else $error("underflow with data or nonzero count");

    // overflow only from a full deque
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == cdq_pkg::ST_OVERFLOW)
        |-> (o_rsp.entry_count == cdq_pkg::ENTRY_COUNT_W'(cdq_pkg::DEPTH)))
        else $error("overflow reported while not full");

endmodule

// ===== dv/circular_deque_tb.sv =====
// ----------------------------------------------------------------------------
// circular_deque_tb: self-checking bench for the circular deque
// a directed opening walks empty, full, overflow, underflow and index wrap
// in both directions, then random push/pop traffic runs under phases of
// sender idling and receiver back-pressure; a scoreboard class mirrors the
// ring and compares every response transaction field by field
// ----------------------------------------------------------------------------
module circular_deque_tb;

    // code 3 has no name in the package; the deque ignores it
    localparam logic [cdq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int ITEMS_PER_PHASE = 350;
    localparam int QUIET_LIMIT     = 4000;
    localparam int TAIL_CYCLES     = 10;

    localparam logic [cdq_pkg::DATA_W-1:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [cdq_pkg::DATA_W-1:0] VAL_MAX  = 32'h7fff_ffff;
    localparam logic [cdq_pkg::DATA_W-1:0] VAL_ONES = 32'hffff_ffff;

    typedef struct {
        logic [cdq_pkg::STATUS_W-1:0]      status;
        logic [cdq_pkg::DATA_W-1:0]        popped;
        logic [cdq_pkg::ENTRY_COUNT_W-1:0] count;
    } t_deque_result;

    // mirror of the ring plus the queue of responses it predicts
    class t_deque_scoreboard;
        logic [cdq_pkg::DATA_W-1:0] slots [cdq_pkg::DEPTH];
        logic [cdq_pkg::IDX_W-1:0]  front_idx;
        logic [cdq_pkg::IDX_W-1:0]  rear_idx;
        bit                         empty;
        t_deque_result              expected_q [$];
        int                         errors;

        function void clear();
            front_idx = '0;
            rear_idx  = '0;
            empty     = 1'b1;
            errors    = 0;
            expected_q.delete();
        endfunction

        function logic [cdq_pkg::IDX_W-1:0] step_up(logic [cdq_pkg::IDX_W-1:0] i);
            return (int'(i) == cdq_pkg::DEPTH - 1) ? '0 : i + 1'b1;
        endfunction

        function logic [cdq_pkg::IDX_W-1:0] step_down(logic [cdq_pkg::IDX_W-1:0] i);
            return (i == '0) ? cdq_pkg::IDX_W'(cdq_pkg::DEPTH - 1) : i - 1'b1;
        endfunction

        function int occupancy();
            if (empty) return 0;
            return ((int'(rear_idx) + cdq_pkg::DEPTH - int'(front_idx))
                    % cdq_pkg::DEPTH) + 1;
        endfunction

        function bit full();
            return !empty && (step_up(rear_idx) == front_idx);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // apply one accepted request to the mirror and queue its response
        function void note_request(logic [cdq_pkg::OP_W-1:0] op,
                                   logic [cdq_pkg::DATA_W-1:0] val);
            t_deque_result r;
            r.status = cdq_pkg::ST_DONE;
            r.popped = '0;
            case (op)
                cdq_pkg::OP_PUSH_REAR, cdq_pkg::OP_PUSH_FRONT: begin
                    if (full()) begin
                        r.status = cdq_pkg::ST_OVERFLOW;
                    end else if (empty) begin
                        front_idx = '0;
                        rear_idx  = '0;
                        empty     = 1'b0;
                        slots[0]  = val;
                    end else if (op == cdq_pkg::OP_PUSH_REAR) begin
                        rear_idx        = step_up(rear_idx);
                        slots[rear_idx] = val;
                    end else begin
                        front_idx        = step_down(front_idx);
                        slots[front_idx] = val;
                    end
                end
                cdq_pkg::OP_POP_FRONT: begin
                    if (empty) begin
                        r.status = cdq_pkg::ST_UNDERFLOW;
                    end else begin
                        r.popped = slots[front_idx];
                        if (front_idx == rear_idx) begin
                            empty     = 1'b1;
                            front_idx = '0;
                            rear_idx  = '0;
                        end else begin
                            front_idx = step_up(front_idx);
                        end
                    end
                end
                default: ;
            endcase
            r.count = cdq_pkg::ENTRY_COUNT_W'(occupancy());
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_response(logic [cdq_pkg::STATUS_W-1:0] status,
                            logic [cdq_pkg::DATA_W-1:0] popped,
                            logic [cdq_pkg::ENTRY_COUNT_W-1:0] count);
            t_deque_result e;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("response with none expected (status %0d)", status));
            end else begin
                e = expected_q.pop_front();
                if (status !== e.status)
                    report_mismatch($sformatf("status got %0d expected %0d", status, e.status));
                if (popped !== e.popped)
                    report_mismatch($sformatf("popped_value got %08h expected %08h",
                                              popped, e.popped));
                if (count !== e.count)
                    report_mismatch($sformatf("entry_count got %0d expected %0d",
                                              count, e.count));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    cdq_req_if req_ch ();
    cdq_rsp_if rsp_ch ();

    circular_deque u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_deque_scoreboard sb;
    int snd_idle_pct;
    int rcv_stall_pct;
    int quiet_cycles;
    bit fill_bias;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    // request acceptance feeds the mirror, response acceptance is checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.operation, req_ch.value);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.status, rsp_ch.popped_value, rsp_ch.entry_count);
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL circular_deque");
                $finish;
            end
        end
    end

    // one request transaction, with random idle cycles ahead of it
    task automatic send_item(logic [cdq_pkg::OP_W-1:0] op,
                             logic [cdq_pkg::DATA_W-1:0] val);
        while ($urandom_range(99) < snd_idle_pct) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.value     <= val;
        @(posedge i_clk);
        while (!(req_ch.valid && req_ch.ready))
            @(posedge i_clk);
    endtask

    // sender goes quiet until every predicted response has come back
    task automatic drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // push-heavy or pop-heavy stretches so the ring swings between empty and full
    task automatic random_item();
        logic [cdq_pkg::OP_W-1:0]   op;
        logic [cdq_pkg::DATA_W-1:0] val;
        int                         roll;
        if ($urandom_range(11) == 0)
            fill_bias = ~fill_bias;
        roll = $urandom_range(99);
        if (roll < 3)
            op = OP_UNUSED;
        else if ((roll < 68) == fill_bias)
            op = $urandom_range(1) ? cdq_pkg::OP_PUSH_FRONT : cdq_pkg::OP_PUSH_REAR;
        else
            op = cdq_pkg::OP_POP_FRONT;
        case ($urandom_range(15))
            0:       val = VAL_MIN;
            1:       val = VAL_MAX;
            2:       val = '0;
            3:       val = VAL_ONES;
            default: val = $urandom;
        endcase
        send_item(op, val);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct);
        snd_idle_pct  = idle_pct;
        rcv_stall_pct = stall_pct;
        for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i == ITEMS_PER_PHASE / 2)
                drain();
            random_item();
        end
        drain();
    endtask

    initial begin
        sb = new();
        sb.clear();
        req_ch.valid     = 1'b0;
        req_ch.operation = cdq_pkg::OP_PUSH_REAR;
        req_ch.value     = '0;
        rsp_ch.ready     = 1'b0;
        snd_idle_pct     = 0;
        rcv_stall_pct    = 0;
        quiet_cycles     = 0;
        fill_bias        = 1'b1;
        i_rst_n          = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening
        send_item(cdq_pkg::OP_POP_FRONT, VAL_ONES);       // underflow on empty
        send_item(cdq_pkg::OP_PUSH_FRONT, VAL_MIN);       // push onto empty lands in slot zero
        send_item(cdq_pkg::OP_PUSH_FRONT, VAL_MAX);       // front wraps below slot zero
        send_item(cdq_pkg::OP_PUSH_REAR, '0);
        send_item(cdq_pkg::OP_PUSH_REAR, VAL_ONES);
        send_item(cdq_pkg::OP_PUSH_REAR, 32'h5555_5555);
        send_item(cdq_pkg::OP_PUSH_REAR, 32'haaaa_aaaa);
        send_item(cdq_pkg::OP_PUSH_REAR, 32'h0000_0001);
        send_item(cdq_pkg::OP_PUSH_REAR, 32'hfffe_0000);  // now full
        send_item(cdq_pkg::OP_PUSH_REAR, 32'h1234_5678);  // overflow at rear
        send_item(cdq_pkg::OP_PUSH_FRONT, 32'h8765_4321); // overflow at front
        send_item(OP_UNUSED, VAL_ONES);                   // ignored while full
        send_item(cdq_pkg::OP_POP_FRONT, '0);             // pop at last slot wraps front
        send_item(cdq_pkg::OP_POP_FRONT, '0);
        send_item(cdq_pkg::OP_PUSH_REAR, 32'h0f0f_0f0f);
        send_item(cdq_pkg::OP_PUSH_REAR, 32'hf0f0_f0f0);  // rear wraps past last slot
        for (int i = 0; i < 8; i++)
            send_item(cdq_pkg::OP_POP_FRONT, $urandom);   // last one empties the deque
        send_item(cdq_pkg::OP_POP_FRONT, '0);             // underflow again
        drain();

        run_phase(0, 0);
        run_phase(45, 0);
        run_phase(0, 45);
        run_phase(15, 15);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected responses never arrived",
                                         sb.pending()));
        if (sb.errors == 0)
            $display("PASS circular_deque");
        else
            $display("FAIL circular_deque");
        $finish;
    end

endmodule
